[hdl/cbmf_pkg.sv]
// Shared types and constants for the complex binary matched filter.
// Used by cbmf_lane, cbmf_merge and complex_binary_matched_filter.
package cbmf_pkg;

  // Filter geometry
  localparam int TAPS        = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 23;
  localparam int MASK_BITS   = 32;

  // Lane split: each lane correlates LANE_TAPS consecutive taps
  localparam int LANES     = 4;
  localparam int LANE_TAPS = (TAPS + LANES - 1) / LANES;
  localparam int PAD_TAPS  = LANES * LANE_TAPS;

  // Partial sum of one lane, and full sum of two correlations
  localparam int LANE_BITS = SAMPLE_BITS + $clog2(LANE_TAPS) + 1;
  localparam int ACC_BITS  = SAMPLE_BITS + $clog2(TAPS) + 2;
  localparam int SUM_BITS  = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INPHASE_MASK    = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUADRATURE_MASK = CFG_INDEX_BITS'(1);

  localparam logic [MASK_BITS-1:0] INPHASE_MASK_RST    = 32'h1CF8_58C5;
  localparam logic [MASK_BITS-1:0] QUADRATURE_MASK_RST = 32'hD7A5_A854;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [LANE_BITS-1:0]   lane_acc_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // Four partial correlations of one lane:
  // ii = I hist x cI, iq = I hist x cQ, qi = Q hist x cI, qq = Q hist x cQ
  typedef struct packed {
    lane_acc_t ii;
    lane_acc_t iq;
    lane_acc_t qi;
    lane_acc_t qq;
  } lane_sum_t;

endpackage

[hdl/cbmf_lane.sv]
// One correlation lane: signed +1/-1 sums over a slice of both delay lines.
// Depends on cbmf_pkg.
module cbmf_lane
  import cbmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  sample_t              hist_i [LANE_TAPS],
  input  sample_t              hist_q [LANE_TAPS],
  input  logic [LANE_TAPS-1:0] sign_i,
  input  logic [LANE_TAPS-1:0] sign_q,
  output lane_sum_t            sum_r
);

  lane_sum_t sum_nxt;

  // Add or subtract each tap according to its sign bit
  always_comb begin
    lane_acc_t ext_i;
    lane_acc_t ext_q;
    sum_nxt = '0;
    for (int j = 0; j < LANE_TAPS; j++) begin
      ext_i = LANE_BITS'(hist_i[j]);
      ext_q = LANE_BITS'(hist_q[j]);
      sum_nxt.ii = sign_i[j] ? sum_nxt.ii + ext_i : sum_nxt.ii - ext_i;
      sum_nxt.iq = sign_q[j] ? sum_nxt.iq + ext_i : sum_nxt.iq - ext_i;
      sum_nxt.qi = sign_i[j] ? sum_nxt.qi + ext_q : sum_nxt.qi - ext_q;
      sum_nxt.qq = sign_q[j] ? sum_nxt.qq + ext_q : sum_nxt.qq - ext_q;
    end
  end

  // Hold partial sums while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

[hdl/cbmf_merge.sv]
// Merging stage: adds the lane partial sums and forms the X and Y results.
// Depends on cbmf_pkg.
module cbmf_merge
  import cbmf_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  lane_sum_t lane_sum [LANES],
  output sum_t      x_r,
  output sum_t      y_r
);

  sum_t x_nxt;
  sum_t y_nxt;

  // Accumulate the four lanes, then combine the correlations
  always_comb begin
    sum_t ii;
    sum_t iq;
    sum_t qi;
    sum_t qq;
    ii = '0;
    iq = '0;
    qi = '0;
    qq = '0;
    for (int l = 0; l < LANES; l++) begin
      ii = ii + SUM_BITS'(lane_sum[l].ii);
      iq = iq + SUM_BITS'(lane_sum[l].iq);
      qi = qi + SUM_BITS'(lane_sum[l].qi);
      qq = qq + SUM_BITS'(lane_sum[l].qq);
    end
    x_nxt = ii + qq;
    y_nxt = qi - iq;
  end

  // Hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

endmodule

[hdl/complex_binary_matched_filter.sv]
// Complex matched filter with 32 binary taps: one complex sample per beat in,
// one (X, Y) correlation pair per beat out. The block takes one sample every
// clock cycle while in_ready is high; each result passes through the three
// registered stages (delay lines, lane partial sums, merged output) before it
// is presented on the out port. Four lanes of eight taps work in parallel and
// the merge stage adds their sums. The output register holds a result while
// out_ready is low and the stages behind it keep filling until all three hold
// a beat. Both delay lines clear to zero at reset; sign masks must be written
// through the cfg port only while no beat is in flight, which the block itself
// does not enforce. Outputs keep full precision.
// Depends on cbmf_pkg, cbmf_lane and cbmf_merge.
module complex_binary_matched_filter
  import cbmf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    in_sample_i,
  input  logic [SAMPLE_BITS-1:0]    in_sample_q,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUT_BITS-1:0]       out_x,
  output logic [OUT_BITS-1:0]       out_y,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [MASK_BITS-1:0]      cfg_data
);

  logic [MASK_BITS-1:0] mask_i_r;
  logic [MASK_BITS-1:0] mask_q_r;
  sample_t              hist_i_r [TAPS];
  sample_t              hist_q_r [TAPS];
  logic                 hist_v_r;
  logic                 lane_v_r;
  logic                 out_v_r;
  logic                 en_out;
  logic                 en_lane;
  logic                 en_hist;
  logic                 in_fire;
  sample_t              pad_i [PAD_TAPS];
  sample_t              pad_q [PAD_TAPS];
  logic [PAD_TAPS-1:0]  pad_sign_i;
  logic [PAD_TAPS-1:0]  pad_sign_q;
  lane_sum_t            lane_sum [LANES];
  sum_t                 x_r;
  sum_t                 y_r;

  // Stage enables: a stage advances when it is empty or its successor advances
  assign en_out  = !out_v_r || out_ready;
  assign en_lane = !lane_v_r || en_out;
  assign en_hist = !hist_v_r || en_lane;
  assign in_ready = en_hist;
  assign in_fire  = in_valid && en_hist;

  // Sign mask registers; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_i_r <= INPHASE_MASK_RST;
      mask_q_r <= QUADRATURE_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPHASE_MASK:    mask_i_r <= cfg_data;
        REG_QUADRATURE_MASK: mask_q_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shift each accepted sample into the delay lines, newest at tap 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        hist_i_r[k] <= '0;
        hist_q_r[k] <= '0;
      end
    end else if (in_fire) begin
      for (int k = TAPS - 1; k > 0; k--) begin
        hist_i_r[k] <= hist_i_r[k-1];
        hist_q_r[k] <= hist_q_r[k-1];
      end
      hist_i_r[0] <= sample_t'(in_sample_i);
      hist_q_r[0] <= sample_t'(in_sample_q);
    end
  end

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_v_r <= 1'b0;
      lane_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (en_hist) begin
        hist_v_r <= in_valid;
      end
      if (en_lane) begin
        lane_v_r <= hist_v_r;
      end
      if (en_out) begin
        out_v_r <= lane_v_r;
      end
    end
  end

  // Pad the taps out to whole lanes; missing taps read as zero, mask bits
  // past the register width read as clear
  for (genvar k = 0; k < PAD_TAPS; k++) begin : g_pad
    if (k < TAPS) begin : g_tap
      assign pad_i[k] = hist_i_r[k];
      assign pad_q[k] = hist_q_r[k];
    end else begin : g_zero
      assign pad_i[k] = '0;
      assign pad_q[k] = '0;
    end
    if (k < MASK_BITS) begin : g_bit
      assign pad_sign_i[k] = mask_i_r[k];
      assign pad_sign_q[k] = mask_q_r[k];
    end else begin : g_clear
      assign pad_sign_i[k] = 1'b0;
      assign pad_sign_q[k] = 1'b0;
    end
  end

  // Correlation lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sample_t lane_i [LANE_TAPS];
    sample_t lane_q [LANE_TAPS];

    for (genvar j = 0; j < LANE_TAPS; j++) begin : g_slice
      assign lane_i[j] = pad_i[l*LANE_TAPS + j];
      assign lane_q[j] = pad_q[l*LANE_TAPS + j];
    end

    cbmf_lane u_lane (
      .clk    (clk),
      .en     (en_lane),
      .hist_i (lane_i),
      .hist_q (lane_q),
      .sign_i (pad_sign_i[l*LANE_TAPS +: LANE_TAPS]),
      .sign_q (pad_sign_q[l*LANE_TAPS +: LANE_TAPS]),
      .sum_r  (lane_sum[l])
    );
  end

  // Merge lanes into the output register
  cbmf_merge u_merge (
    .clk      (clk),
    .en       (en_out),
    .lane_sum (lane_sum),
    .x_r      (x_r),
    .y_r      (y_r)
  );

  assign out_valid = out_v_r;
  assign out_x     = x_r[OUT_BITS-1:0];
  assign out_y     = y_r[OUT_BITS-1:0];

  // Accepted beat lands in the delay-line stage
  a_accept_fills_hist: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> hist_v_r)
    else $error("accepted beat did not reach the delay-line stage");

  // Empty output register never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled with an empty output register");

  // Stalled delay lines hold their newest tap
  a_hist_holds: assert property (@(posedge clk) disable iff (!rst_n)
    hist_v_r && !en_lane |=> hist_v_r && $stable(hist_i_r[0]) && $stable(hist_q_r[0]))
    else $error("delay lines moved while stalled");

  // Lane results that advance reach the output
  a_lane_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    lane_v_r && en_out |=> out_v_r)
    else $error("lane beat lost on its way to the output");

endmodule
